>>> rtl/uscal_pkg.sv
// Shared constants, types and the month-length table of the calendar converter.
`timescale 1ns / 1ps
`default_nettype none
package uscal_pkg;

  localparam int IN_W    = 35;  // seconds since epoch
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam logic [IN_W-1:0]   SECS_PER_DAY   = IN_W'(86400);
  localparam logic [IN_W-1:0]   SECS_PER_HOUR  = IN_W'(3600);
  localparam logic [IN_W-1:0]   SECS_PER_MIN   = IN_W'(60);
  localparam logic [YEAR_W-1:0] EPOCH_YEAR     = YEAR_W'(1970);
  // 1970 taken mod 4, mod 100 and mod 400
  localparam logic [1:0]        EPOCH_MOD4     = 2'd2;
  localparam logic [6:0]        EPOCH_MOD100   = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400   = 9'd370;
  localparam logic [8:0]        DAYS_COMMON    = 9'd365;
  localparam logic [8:0]        DAYS_LEAP      = 9'd366;
  localparam logic [IN_W-1:0]   SECS_COMMON_YEAR = IN_W'(DAYS_COMMON) * SECS_PER_DAY;
  localparam logic [IN_W-1:0]   SECS_LEAP_YEAR   = IN_W'(DAYS_LEAP) * SECS_PER_DAY;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_DEC     = MONTH_W'(11);

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic day_step;
    logic hour_step;
    logic min_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic year_done;
    logic month_done;
    logic day_done;
    logic hour_done;
    logic min_done;
  } sts_t;

  // Days in a common year's month, month index from 0
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Seconds in a month of the given length in days
  function automatic logic [IN_W-1:0] month_secs(input logic [DAY_W-1:0] len);
    logic [IN_W-1:0] s;
    case (len)
      5'd28:   s = IN_W'(28) * SECS_PER_DAY;
      5'd29:   s = IN_W'(29) * SECS_PER_DAY;
      5'd30:   s = IN_W'(30) * SECS_PER_DAY;
      default: s = IN_W'(31) * SECS_PER_DAY;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/uscal_datapath.sv
// Datapath: year, month, day and time-of-day walks on the seconds count, result registers.
`timescale 1ns / 1ps
`default_nettype none
module uscal_datapath (
  input  wire logic                          clk,
  input  wire uscal_pkg::cmd_t               cmd,
  output uscal_pkg::sts_t                    sts,
  input  wire logic [uscal_pkg::IN_W-1:0]    in_epoch_seconds,
  output logic [uscal_pkg::YEAR_W-1:0]       out_year,
  output logic [uscal_pkg::MONTH_W-1:0]      out_month,
  output logic [uscal_pkg::DAY_W-1:0]        out_day_of_month,
  output logic [uscal_pkg::HOUR_W-1:0]       out_hour,
  output logic [uscal_pkg::MIN_W-1:0]        out_minute,
  output logic [uscal_pkg::SEC_W-1:0]        out_second
);

  logic [uscal_pkg::IN_W-1:0]    secs_r;
  logic [uscal_pkg::YEAR_W-1:0]  year_r;
  logic [uscal_pkg::MONTH_W-1:0] mon_r;
  logic [uscal_pkg::DAY_W-1:0]   mday_r;
  logic [uscal_pkg::HOUR_W-1:0]  hour_r;
  logic [uscal_pkg::MIN_W-1:0]   min_r;
  logic [1:0]                    y4_r;
  logic [6:0]                    y100_r;
  logic [8:0]                    y400_r;

  logic [uscal_pkg::YEAR_W-1:0]  year_o_r;
  logic [uscal_pkg::MONTH_W-1:0] month_o_r;
  logic [uscal_pkg::DAY_W-1:0]   dom_o_r;
  logic [uscal_pkg::HOUR_W-1:0]  hour_o_r;
  logic [uscal_pkg::MIN_W-1:0]   min_o_r;
  logic [uscal_pkg::SEC_W-1:0]   sec_o_r;

  logic                          leap;
  logic [uscal_pkg::IN_W-1:0]    ylen_secs;
  logic [uscal_pkg::DAY_W-1:0]   mlen;
  logic [uscal_pkg::IN_W-1:0]    mlen_secs;
  logic                          year_ge;
  logic                          month_ge;
  logic                          day_ge;
  logic                          hour_ge;
  logic                          min_ge;

  assign leap = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen_secs = leap ? uscal_pkg::SECS_LEAP_YEAR : uscal_pkg::SECS_COMMON_YEAR;
  assign mlen = uscal_pkg::month_days(mon_r)
              + uscal_pkg::DAY_W'((mon_r == uscal_pkg::MONTH_FEB) && leap);
  assign mlen_secs = uscal_pkg::month_secs(mlen);

  // Whole days compare the same in seconds, since the time of day stays below one day
  assign year_ge  = (secs_r >= ylen_secs);
  assign month_ge = (mon_r != uscal_pkg::MONTH_DEC) && (secs_r >= mlen_secs);
  assign day_ge   = (secs_r >= uscal_pkg::SECS_PER_DAY);
  assign hour_ge  = (secs_r >= uscal_pkg::SECS_PER_HOUR);
  assign min_ge   = (secs_r >= uscal_pkg::SECS_PER_MIN);

  assign sts.year_done  = !year_ge;
  assign sts.month_done = !month_ge;
  assign sts.day_done   = !day_ge;
  assign sts.hour_done  = !hour_ge;
  assign sts.min_done   = !min_ge;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs_r <= in_epoch_seconds;
      year_r <= uscal_pkg::EPOCH_YEAR;
      mon_r  <= '0;
      mday_r <= '0;
      hour_r <= '0;
      min_r  <= '0;
      y4_r   <= uscal_pkg::EPOCH_MOD4;
      y100_r <= uscal_pkg::EPOCH_MOD100;
      y400_r <= uscal_pkg::EPOCH_MOD400;
    end
    if (cmd.year_step && year_ge) begin
      secs_r <= secs_r - ylen_secs;
      year_r <= year_r + 1'b1;
      y4_r   <= y4_r + 1'b1;
      y100_r <= (y100_r == 7'd99)  ? 7'd0 : y100_r + 1'b1;
      y400_r <= (y400_r == 9'd399) ? 9'd0 : y400_r + 1'b1;
    end
    if (cmd.month_step && month_ge) begin
      secs_r <= secs_r - mlen_secs;
      mon_r  <= mon_r + 1'b1;
    end
    if (cmd.day_step && day_ge) begin
      secs_r <= secs_r - uscal_pkg::SECS_PER_DAY;
      mday_r <= mday_r + 1'b1;
    end
    if (cmd.hour_step && hour_ge) begin
      secs_r <= secs_r - uscal_pkg::SECS_PER_HOUR;
      hour_r <= hour_r + 1'b1;
    end
    if (cmd.min_step && min_ge) begin
      secs_r <= secs_r - uscal_pkg::SECS_PER_MIN;
      min_r  <= min_r + 1'b1;
    end
    if (cmd.out_load) begin
      year_o_r  <= year_r;
      month_o_r <= mon_r + 1'b1;
      dom_o_r   <= mday_r + 1'b1;
      hour_o_r  <= hour_r;
      min_o_r   <= min_r;
      sec_o_r   <= uscal_pkg::SEC_W'(secs_r);
    end
  end

  assign out_year         = year_o_r;
  assign out_month        = month_o_r;
  assign out_day_of_month = dom_o_r;
  assign out_hour         = hour_o_r;
  assign out_minute       = min_o_r;
  assign out_second       = sec_o_r;

endmodule
`default_nettype wire

>>> rtl/uscal_ctrl.sv
// Controller: sequences the conversion phases and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none
module uscal_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire uscal_pkg::sts_t sts,
  output uscal_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_DAY   = 3'd3;
  localparam logic [2:0] S_HOUR  = 3'd4;
  localparam logic [2:0] S_MIN   = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.load       = in_valid && (state_r == S_IDLE);
    cmd.year_step  = (state_r == S_YEAR);
    cmd.month_step = (state_r == S_MONTH);
    cmd.day_step   = (state_r == S_DAY);
    cmd.hour_step  = (state_r == S_HOUR);
    cmd.min_step   = (state_r == S_MIN);
    cmd.out_load   = (state_r == S_PUSH) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid)       state_nxt = S_YEAR;
      S_YEAR:  if (sts.year_done)  state_nxt = S_MONTH;
      S_MONTH: if (sts.month_done) state_nxt = S_DAY;
      S_DAY:   if (sts.day_done)   state_nxt = S_HOUR;
      S_HOUR:  if (sts.hour_done)  state_nxt = S_MIN;
      S_MIN:   if (sts.min_done)   state_nxt = S_PUSH;
      S_PUSH:  if (slot_free)      state_nxt = S_IDLE;
      default:                     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/unix_seconds_to_calendar_top.sv
// Top level of the Unix-seconds to Gregorian date and time-of-day converter.
// Each beat on the input carries a 35-bit count of seconds since 1970-01-01
// 00:00:00 and yields exactly one output beat with year, month, day of
// month, hour, minute and second (no time zone). Items are handled one at a
// time. The count is walked down in place by compare and subtract: first one
// year per step since 1970, then one full month, one full day of the month,
// one hour and one minute per step, each walk ending on a failed compare, and
// last the result is posted, once the output register is free. The year walk
// is the longest of the walks, since the largest count lands in October 3058.
// in_ready is high only between items, so the next beat is taken at the
// earliest in the cycle after the result is posted; a new item may be taken
// while the previous result still waits in the output register, and its
// result is posted only once that register is free.
`timescale 1ns / 1ps
`default_nettype none
module unix_seconds_to_calendar_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [uscal_pkg::IN_W-1:0]    in_epoch_seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [uscal_pkg::YEAR_W-1:0]       out_year,
  output logic [uscal_pkg::MONTH_W-1:0]      out_month,
  output logic [uscal_pkg::DAY_W-1:0]        out_day_of_month,
  output logic [uscal_pkg::HOUR_W-1:0]       out_hour,
  output logic [uscal_pkg::MIN_W-1:0]        out_minute,
  output logic [uscal_pkg::SEC_W-1:0]        out_second
);

  // Command and status groups between sequencer and datapath
  uscal_pkg::cmd_t cmd;
  uscal_pkg::sts_t sts;

  uscal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath holds working registers and the output register set
  uscal_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_epoch_seconds (in_epoch_seconds),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

endmodule
`default_nettype wire

>>> rtl/uscal_checker.sv
// Port-level checker for the calendar converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module uscal_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [uscal_pkg::YEAR_W-1:0]  out_year,
  input wire logic [uscal_pkg::MONTH_W-1:0] out_month,
  input wire logic [uscal_pkg::DAY_W-1:0]   out_day_of_month,
  input wire logic [uscal_pkg::HOUR_W-1:0]  out_hour,
  input wire logic [uscal_pkg::MIN_W-1:0]   out_minute,
  input wire logic [uscal_pkg::SEC_W-1:0]   out_second
);

  // A stalled result beat holds valid and its year, month, day and second
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day_of_month) && $stable(out_second))
    else $error("stalled output beat changed");

  // An accepted beat keeps the block busy for at least the year and month walks
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while busy");

  // Date fields stay in range: month 1 to 12, day at least 1, year 1970 to 3059
  a_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12)
      && (out_day_of_month >= 5'd1) && (out_year >= 12'd1970) && (out_year <= 12'd3059))
    else $error("date field out of range");

  // Time fields stay in range
  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("time field out of range");

endmodule

bind unix_seconds_to_calendar_top uscal_checker u_uscal_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month),
  .out_hour         (out_hour),
  .out_minute       (out_minute),
  .out_second       (out_second)
);
`default_nettype wire
